>>> rtl/qssg_pkg.sv
// qssg_pkg: shared types and constants of the quadrature step state generator
// no dependencies; every other rtl file but qssg_stream_if takes names from here by scope
`default_nettype none

package qssg_pkg;

   // default configuration handed to the top level
   localparam int STATES_PER_TICK_DEFAULT = 20;
   localparam int FIFO_DEPTH_DEFAULT      = 8;

   // largest supported number of states per tick and the lane index width
   localparam int MAX_STATES = 32;
   localparam int LANE_W     = $clog2(MAX_STATES);

   // fixed point scale of the reciprocal used to spread steps over states
   localparam int RECIP_SHIFT = 20;

   // request function codes
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_SET_REF = 1'b1;

   typedef struct packed {
      logic               func;
      logic signed [31:0] commanded_position;
      logic [3:0]         fifo_free;
   } qssg_req_type;

   typedef struct packed {
      logic [31:0]        state_word;
      logic               word_valid;
      logic               word_dropped;
      logic [31:0]        drop_total;
      logic signed [31:0] emitted_reference;
      logic [1:0]         quad_phase;
      logic               last;
   } qssg_rsp_type;

   // all results caused by one request, queued as a unit
   typedef struct packed {
      qssg_rsp_type [1:0] results;
      logic               two_results;
   } qssg_record_type;

   // architectural state carried from one request to the next
   typedef struct packed {
      logic [1:0]  phase_index;
      logic [31:0] reference_position;
      logic [31:0] packing_word;
      logic [3:0]  states_in_word;
      logic [1:0]  phase_snapshot;
      logic [31:0] reference_snapshot;
      logic [31:0] dropped_words;
   } qssg_state_type;

endpackage

`default_nettype wire

>>> rtl/qssg_stream_if.sv
// qssg_stream_if: valid/ready channel carrying one payload per transfer
// payload type is set where the channel is instantiated
`default_nettype none

interface qssg_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/qssg_lanes.sv
// qssg_lanes: per-state cumulative transition counts of the step spreader
// depends on qssg_pkg; lane i gives floor((i+1)*n/STATES_PER_TICK)
`default_nettype none

module qssg_lanes #(
   parameter int STATES_PER_TICK = qssg_pkg::STATES_PER_TICK_DEFAULT
) (
   input  logic [5:0] step_count,
   output logic [5:0] lane_steps [qssg_pkg::MAX_STATES]
);
   // ceil(2^shift / states): exact for every product below 2^shift / 32
   localparam int Recip =
      ((1 << qssg_pkg::RECIP_SHIFT) + STATES_PER_TICK - 1) / STATES_PER_TICK;

   for (genvar i = 0; i < qssg_pkg::MAX_STATES; i++) begin : g_lane
      if (i < STATES_PER_TICK) begin : g_used
         localparam logic [21:0] LaneScale = 22'((i + 1) * Recip);
         logic [27:0] product;
         assign product       = 28'(step_count) * 28'(LaneScale);
         assign lane_steps[i] = product[qssg_pkg::RECIP_SHIFT +: 6];
      end else begin : g_unused
         assign lane_steps[i] = 6'd0;
      end
   end
endmodule

`default_nettype wire

>>> rtl/qssg_tick.sv
// qssg_tick: combinational evaluation of one request against the state
// depends on qssg_pkg and qssg_lanes; yields the next state and all results
`default_nettype none

module qssg_tick #(
   parameter int STATES_PER_TICK = qssg_pkg::STATES_PER_TICK_DEFAULT,
   parameter int FIFO_DEPTH      = qssg_pkg::FIFO_DEPTH_DEFAULT
) (
   input  qssg_pkg::qssg_req_type    req,
   input  qssg_pkg::qssg_state_type  state,
   output qssg_pkg::qssg_state_type  state_next,
   output qssg_pkg::qssg_record_type record
);
   localparam int          LaneCount  = qssg_pkg::MAX_STATES;
   localparam logic [qssg_pkg::LANE_W-1:0] LastLane =
      qssg_pkg::LANE_W'(STATES_PER_TICK - 1);
   localparam logic [5:0]  StatesTick = 6'(STATES_PER_TICK);
   localparam logic [24:0] StepClamp  = 25'(STATES_PER_TICK);
   localparam logic        SingleSlot = (FIFO_DEPTH < 2);

   // a point is a value relative to the current or the snapshot base
   typedef struct packed {
      logic       use_snap;
      logic [5:0] k;
   } point_type;

   function automatic logic [1:0] gray(input logic [1:0] phase);
      logic [1:0] code;
      unique case (phase)
         2'd0: code = 2'b00;
         2'd1: code = 2'b01;
         2'd2: code = 2'b11;
         2'd3: code = 2'b10;
         default: code = 2'b00;
      endcase
      return code;
   endfunction

   // count along a segment: base count plus steps since segment start
   function automatic logic [5:0] advance(input logic [5:0] k, input logic [5:0] t,
                                          input logic [5:0] t_start);
      logic [6:0] sum;
      sum = 7'(k) + 7'(t) - 7'(t_start);
      return sum[5:0];
   endfunction

   function automatic logic [31:0] point_ref(input point_type pt, input logic fwd,
                                             input logic [31:0] cur,
                                             input logic [31:0] snap);
      logic [31:0] base;
      logic [31:0] offset;
      base   = pt.use_snap ? snap : cur;
      offset = {18'd0, pt.k, 8'd0};
      return fwd ? base + offset : base - offset;
   endfunction

   function automatic logic [1:0] point_phase(input point_type pt, input logic fwd,
                                              input logic [1:0] cur,
                                              input logic [1:0] snap);
      logic [1:0] base;
      base = pt.use_snap ? snap : cur;
      return fwd ? base - pt.k[1:0] : base + pt.k[1:0];
   endfunction

   logic [32:0] cmd_x;
   logic [32:0] ref_x;
   logic [32:0] diff_fwd;
   logic [32:0] diff_back;
   logic [32:0] magnitude;
   logic        fwd;
   logic [24:0] whole_steps;
   logic [5:0]  step_count;
   logic [5:0]  lane_steps [LaneCount];
   logic [5:0]  span;
   logic [1:0]  words;
   logic [qssg_pkg::LANE_W-1:0] b1_idx;
   logic [qssg_pkg::LANE_W-1:0] b2_idx;
   logic [5:0]  t_b1;
   logic [5:0]  t_b2;
   logic [5:0]  t_last;
   logic        drop1;
   logic        drop2;
   logic        dr1;
   logic        dr2;
   point_type   snap1;
   point_type   snap2;
   point_type   final_pt;
   point_type   snapshot_pt;
   logic [63:0] lane_bits;
   logic [95:0] pos_bits;
   qssg_pkg::qssg_rsp_type status_rsp;
   qssg_pkg::qssg_rsp_type first_rsp;
   qssg_pkg::qssg_rsp_type second_rsp;

   // signed difference at 33 bits, magnitude from whichever side is positive
   assign cmd_x       = {req.commanded_position[31], req.commanded_position};
   assign ref_x       = {state.reference_position[31], state.reference_position};
   assign diff_fwd    = cmd_x - ref_x;
   assign diff_back   = ref_x - cmd_x;
   assign fwd         = ~diff_fwd[32];
   assign magnitude   = fwd ? diff_fwd : diff_back;
   assign whole_steps = magnitude[32:8];
   assign step_count  = (whole_steps > StepClamp) ? StatesTick : whole_steps[5:0];

   qssg_lanes #(
      .STATES_PER_TICK(STATES_PER_TICK)
   ) u_lanes (
      .step_count(step_count),
      .lane_steps(lane_steps)
   );

   // word boundaries fall on states 15-s and 31-s
   assign span   = 6'(state.states_in_word) + StatesTick;
   assign words  = span[5:4];
   assign b1_idx = qssg_pkg::LANE_W'({1'b0, ~state.states_in_word});
   assign b2_idx = qssg_pkg::LANE_W'({1'b1, ~state.states_in_word});
   assign t_b1   = lane_steps[b1_idx];
   assign t_b2   = lane_steps[b2_idx];
   assign t_last = lane_steps[LastLane];

   assign drop1 = (req.fifo_free == 4'd0);
   assign drop2 = (req.fifo_free < 4'd2) || SingleSlot;
   assign dr1   = (words != 2'd0) && drop1;
   assign dr2   = (words == 2'd2) && drop2;

   // values after each completed word, with rollback on a drop
   assign snap1.use_snap = drop1;
   assign snap1.k        = drop1 ? 6'd0 : t_b1;
   assign snap2.use_snap = snap1.use_snap;
   assign snap2.k        = drop2 ? snap1.k : advance(snap1.k, t_b2, t_b1);

   always_comb begin
      unique case (words)
         2'd0: begin
            final_pt    = '{use_snap: 1'b0, k: t_last};
            snapshot_pt = '{use_snap: 1'b1, k: 6'd0};
         end
         2'd1: begin
            final_pt    = '{use_snap: snap1.use_snap, k: advance(snap1.k, t_last, t_b1)};
            snapshot_pt = snap1;
         end
         default: begin
            final_pt    = '{use_snap: snap2.use_snap, k: advance(snap2.k, t_last, t_b2)};
            snapshot_pt = snap2;
         end
      endcase
   end

   // gray-coded pin state of every output state
   for (genvar i = 0; i < LaneCount; i++) begin : g_state
      if (i < STATES_PER_TICK) begin : g_used
         logic [5:0] pos;
         logic [5:0] cnt;
         logic [1:0] base;
         assign pos  = 6'(state.states_in_word) + 6'(i);
         assign cnt  = (pos[5:4] == 2'd0) ? lane_steps[i] :
                       (pos[5:4] == 2'd1) ? advance(snap1.k, lane_steps[i], t_b1) :
                                            advance(snap2.k, lane_steps[i], t_b2);
         assign base = ((pos[5:4] == 2'd0) ? 1'b0 :
                        (pos[5:4] == 2'd1) ? snap1.use_snap : snap2.use_snap)
                       ? state.phase_snapshot : state.phase_index;
         assign lane_bits[2*i +: 2] = gray(fwd ? base - cnt[1:0] : base + cnt[1:0]);
      end else begin : g_unused
         assign lane_bits[2*i +: 2] = 2'b00;
      end
   end

   // place the new states after the partial word
   assign pos_bits = ({32'd0, lane_bits} << {state.states_in_word, 1'b0})
                     | {64'd0, state.packing_word};

   always_comb begin
      status_rsp.state_word        = 32'd0;
      status_rsp.word_valid        = 1'b0;
      status_rsp.word_dropped      = 1'b0;
      status_rsp.drop_total        = state.dropped_words;
      status_rsp.emitted_reference = point_ref(final_pt, fwd, state.reference_position,
                                               state.reference_snapshot);
      status_rsp.quad_phase        = point_phase(final_pt, fwd, state.phase_index,
                                                 state.phase_snapshot);
      status_rsp.last              = 1'b1;

      first_rsp.state_word        = pos_bits[31:0];
      first_rsp.word_valid        = 1'b1;
      first_rsp.word_dropped      = drop1;
      first_rsp.drop_total        = state.dropped_words + 32'(dr1);
      first_rsp.emitted_reference = point_ref(snap1, fwd, state.reference_position,
                                              state.reference_snapshot);
      first_rsp.quad_phase        = point_phase(snap1, fwd, state.phase_index,
                                                state.phase_snapshot);
      first_rsp.last              = (words == 2'd1);

      second_rsp.state_word        = pos_bits[63:32];
      second_rsp.word_valid        = 1'b1;
      second_rsp.word_dropped      = drop2;
      second_rsp.drop_total        = state.dropped_words + 32'(dr1) + 32'(dr2);
      second_rsp.emitted_reference = point_ref(snap2, fwd, state.reference_position,
                                               state.reference_snapshot);
      second_rsp.quad_phase        = point_phase(snap2, fwd, state.phase_index,
                                                 state.phase_snapshot);
      second_rsp.last              = 1'b1;

      state_next = state;
      record.results[1] = second_rsp;

      if (req.func == qssg_pkg::FUNC_SET_REF) begin
         state_next.reference_position = req.commanded_position;
         state_next.reference_snapshot = req.commanded_position;
         state_next.phase_snapshot     = state.phase_index;
         record.results[0]                   = status_rsp;
         record.results[0].drop_total        = state.dropped_words;
         record.results[0].emitted_reference = req.commanded_position;
         record.results[0].quad_phase        = state.phase_index;
         record.two_results                  = 1'b0;
      end else begin
         state_next.phase_index        = status_rsp.quad_phase;
         state_next.reference_position = status_rsp.emitted_reference;
         state_next.phase_snapshot     = point_phase(snapshot_pt, fwd, state.phase_index,
                                                     state.phase_snapshot);
         state_next.reference_snapshot = point_ref(snapshot_pt, fwd,
                                                   state.reference_position,
                                                   state.reference_snapshot);
         state_next.states_in_word     = span[3:0];
         state_next.dropped_words      = second_rsp.drop_total;
         unique case (words)
            2'd0: begin
               state_next.packing_word = pos_bits[31:0];
               record.results[0]       = status_rsp;
               record.two_results      = 1'b0;
            end
            2'd1: begin
               state_next.packing_word = pos_bits[63:32];
               record.results[0]       = first_rsp;
               record.two_results      = 1'b0;
            end
            default: begin
               state_next.packing_word = pos_bits[95:64];
               record.results[0]       = first_rsp;
               record.two_results      = 1'b1;
            end
         endcase
      end
   end
endmodule

`default_nettype wire

>>> rtl/qssg_rsp_queue.sv
// qssg_rsp_queue: two-record result queue driving the response channel
// depends on qssg_pkg and qssg_stream_if; a record holds one or two results
`default_nettype none

module qssg_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  qssg_pkg::qssg_record_type push_record,
   output logic                      full,
   qssg_stream_if.source             rsp_if
);
   qssg_pkg::qssg_record_type mem_ff [2];
   qssg_pkg::qssg_record_type head;
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       sub_ff;
   logic       sub_in;
   logic       transfer;
   logic       pop;

   assign head           = mem_ff[rd_ptr_ff];
   assign full           = (count_ff == 2'd2);
   assign rsp_if.valid   = (count_ff != 2'd0);
   assign rsp_if.payload = sub_ff ? head.results[1] : head.results[0];
   assign transfer       = rsp_if.valid && rsp_if.ready;
   // record leaves after its final result transfer
   assign pop            = transfer && (sub_ff || !head.two_results);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
      sub_in    = transfer ? !pop : sub_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_record;
      end
   end
endmodule

`default_nettype wire

>>> rtl/quadrature_step_state_generator_core.sv
// quadrature_step_state_generator_core: top level of the step state generator
// depends on qssg_pkg, qssg_stream_if, qssg_tick, qssg_lanes and qssg_rsp_queue
//
//   channel | direction | payload         | transfer when
//   req_if  | in        | qssg_req_type   | req_if.valid && req_if.ready
//   rsp_if  | out       | qssg_rsp_type   | rsp_if.valid && rsp_if.ready
//
// a request is registered, evaluated combinationally against the state and pushed
// as one record into a two-record result queue that drains to rsp_if.
// one request per cycle is taken while the queue is not full, results drain one
// per cycle while ready is high; two completed words give two result transfers.
// reset clears the state to zero and empties the queue.
// a stalled response side holds requests once both queue records are taken.
`default_nettype none

module quadrature_step_state_generator_core #(
   parameter int STATES_PER_TICK = qssg_pkg::STATES_PER_TICK_DEFAULT,
   parameter int FIFO_DEPTH      = qssg_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   qssg_stream_if.sink   req_if,
   qssg_stream_if.source rsp_if
);
   // input register
   logic                      req_valid_ff;
   logic                      req_valid_in;
   qssg_pkg::qssg_req_type    req_data_ff;

   // architectural state
   qssg_pkg::qssg_state_type  state_ff;
   qssg_pkg::qssg_state_type  state_in;

   qssg_pkg::qssg_record_type record;
   logic                      queue_full;
   logic                      commit;
   logic                      req_transfer;

   // the registered request retires once its record fits in the queue
   assign commit       = req_valid_ff && !queue_full;
   assign req_if.ready = !req_valid_ff || commit;
   assign req_transfer = req_if.valid && req_if.ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_transfer) begin
         req_valid_in = 1'b1;
      end else if (commit) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         if (commit) begin
            state_ff <= state_in;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         req_data_ff <= req_if.payload;
      end
   end

   // step spreading, gray packing and drop rollback
   qssg_tick #(
      .STATES_PER_TICK(STATES_PER_TICK),
      .FIFO_DEPTH     (FIFO_DEPTH)
   ) u_tick (
      .req       (req_data_ff),
      .state     (state_ff),
      .state_next(state_in),
      .record    (record)
   );

   // result queue feeding the response channel
   qssg_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (commit),
      .push_record(record),
      .full       (queue_full),
      .rsp_if     (rsp_if)
   );
endmodule

`default_nettype wire

>>> tb/tb_quadrature_step_state_generator_core.sv
`timescale 1ns / 100ps
// tb_quadrature_step_state_generator_core: self-checking bench for the step state generator core
// depends on qssg_pkg, qssg_stream_if and quadrature_step_state_generator_core
// an in-line model predicts every result; directed requests first, then random traffic

module tb_quadrature_step_state_generator_core;

   localparam int STATES       = qssg_pkg::STATES_PER_TICK_DEFAULT;
   localparam int DEPTH        = qssg_pkg::FIFO_DEPTH_DEFAULT;
   localparam int WORD_STATES  = 16;
   localparam int STEP_Q8      = 256;
   localparam int NEAR_SPAN    = 30 * STEP_Q8;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 900;
   localparam int QUIET_ITEMS  = 150;
   localparam int MAX_REPORTS  = 10;

   logic clock;
   logic reset;

   qssg_stream_if #(.payload_type(qssg_pkg::qssg_req_type)) req_if ();
   qssg_stream_if #(.payload_type(qssg_pkg::qssg_rsp_type)) rsp_if ();

   quadrature_step_state_generator_core #(
      .STATES_PER_TICK(STATES),
      .FIFO_DEPTH     (DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // generator state as the bench sees it, advanced at each request transfer
   logic [1:0]         phase_now;
   logic signed [31:0] ref_now;
   logic [31:0]        word_acc;
   int                 word_fill;
   logic [1:0]         phase_at_word;
   logic signed [31:0] ref_at_word;
   logic [31:0]        drop_count;

   // results still owed by the core, oldest first
   qssg_pkg::qssg_rsp_type upcoming_words [$];

   int error_count;
   bit idling_on;
   int calm_items;
   int stall_left;
   int steady_left;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // gray code of a quadrature phase index: 00, 01, 11, 10
   function automatic logic [1:0] gray_of(input logic [1:0] ph);
      case (ph)
         2'd0: gray_of = 2'b00;
         2'd1: gray_of = 2'b01;
         2'd2: gray_of = 2'b11;
         default: gray_of = 2'b10;
      endcase
   endfunction

   // result record built from the state as it stands now
   function automatic qssg_pkg::qssg_rsp_type make_rsp(input logic [31:0] word,
                                                       input logic valid,
                                                       input logic dropped,
                                                       input logic is_last);
      qssg_pkg::qssg_rsp_type r;
      r.state_word        = word;
      r.word_valid        = valid;
      r.word_dropped      = dropped;
      r.drop_total        = drop_count;
      r.emitted_reference = ref_now;
      r.quad_phase        = phase_now;
      r.last              = is_last;
      return r;
   endfunction

   // one request: spread the step count over the tick's states and pack the words
   function automatic void generate_states(input qssg_pkg::qssg_req_type item);
      longint                 diff;
      longint                 whole;
      int                     steps;
      int                     acc;
      int                     slots;
      int                     i;
      int                     made_n;
      bit                     fwd;
      logic                   dropped;
      logic [31:0]            done_word;
      qssg_pkg::qssg_rsp_type made [2];
      if (item.func == qssg_pkg::FUNC_SET_REF) begin
         // load reference and snapshots, partial word stays as it is
         ref_now       = item.commanded_position;
         ref_at_word   = item.commanded_position;
         phase_at_word = phase_now;
         upcoming_words.push_back(make_rsp('0, 1'b0, 1'b0, 1'b1));
         return;
      end
      slots  = (int'(item.fifo_free) > DEPTH) ? DEPTH : int'(item.fifo_free);
      // 33-bit difference cannot overflow in a longint
      diff   = longint'(item.commanded_position) - longint'(ref_now);
      fwd    = (diff >= 0);
      whole  = (fwd ? diff : -diff) >> 8;
      steps  = (whole > STATES) ? STATES : int'(whole);
      acc    = 0;
      made_n = 0;
      for (i = 0; i < STATES; i++) begin
         acc += steps;
         if (acc >= STATES) begin
            acc -= STATES;
            phase_now = phase_now + (fwd ? 2'd3 : 2'd1);
            ref_now   = fwd ? ref_now + STEP_Q8 : ref_now - STEP_Q8;
         end
         word_acc = word_acc | (32'(gray_of(phase_now)) << (2 * word_fill));
         word_fill++;
         if (word_fill >= WORD_STATES) begin
            done_word = word_acc;
            dropped   = 1'b0;
            if (slots > 0) begin
               slots--;
            end else begin
               // fifo full: count the drop and roll back to the word start
               dropped    = 1'b1;
               drop_count = drop_count + 1;
               phase_now  = phase_at_word;
               ref_now    = ref_at_word;
            end
            word_acc      = '0;
            word_fill     = 0;
            phase_at_word = phase_now;
            ref_at_word   = ref_now;
            if (made_n < 2) begin
               made[made_n] = make_rsp(done_word, 1'b1, dropped, 1'b0);
               made_n++;
            end
         end
      end
      if (made_n == 0) begin
         upcoming_words.push_back(make_rsp('0, 1'b0, 1'b0, 1'b1));
      end else begin
         made[made_n - 1].last = 1'b1;
         for (i = 0; i < made_n; i++) begin
            upcoming_words.push_back(made[i]);
         end
      end
   endfunction

   // compare one field, report only the first few misses
   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t %s mismatch: expected %h, got %h", $time, name, want_v, got_v);
         end
      end
   endtask

   // result checker, sampled at the rising edge
   always @(posedge clock) begin
      qssg_pkg::qssg_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (upcoming_words.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t result transfer with nothing expected: %h", $time,
                        rsp_if.payload);
            end
         end else begin
            want = upcoming_words.pop_front();
            check_field("state_word", want.state_word, rsp_if.payload.state_word);
            check_field("word_valid", want.word_valid, rsp_if.payload.word_valid);
            check_field("word_dropped", want.word_dropped, rsp_if.payload.word_dropped);
            check_field("drop_total", want.drop_total, rsp_if.payload.drop_total);
            check_field("emitted_reference", want.emitted_reference,
                        rsp_if.payload.emitted_reference);
            check_field("quad_phase", want.quad_phase, rsp_if.payload.quad_phase);
            check_field("last", want.last, rsp_if.payload.last);
         end
      end
   end

   // result side backpressure: stall bursts, steady stretches, none once idling is off
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!idling_on || steady_left > 0) begin
         if (steady_left > 0) steady_left--;
         rsp_if.ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 15))
            0, 1: begin
               stall_left = $urandom_range(1, 14) - 1;
               rsp_if.ready <= 1'b0;
            end
            2: begin
               steady_left = $urandom_range(20, 80);
               rsp_if.ready <= 1'b1;
            end
            default: rsp_if.ready <= 1'b1;
         endcase
      end
   end

   // watchdog: too long without any transfer ends the run
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // drop valid and hold off for a number of cycles, entered at a falling edge
   task automatic idle_sender(input int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // random gap before a request, with stretches of back-to-back transfers
   task automatic sender_gap();
      if (!idling_on) return;
      if (calm_items > 0) begin
         calm_items--;
         return;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: idle_sender($urandom_range(1, 14));
         3: calm_items = $urandom_range(10, 40);
         default: ;
      endcase
   endtask

   // one request transfer; valid stays up so the next one can follow directly
   task automatic send_item(input qssg_pkg::qssg_req_type item);
      req_if.payload <= item;
      req_if.valid   <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      generate_states(item);
      @(negedge clock);
   endtask

   task automatic send_cmd(input logic func, input logic signed [31:0] pos,
                           input logic [3:0] free);
      qssg_pkg::qssg_req_type item;
      item.func               = func;
      item.commanded_position = pos;
      item.fifo_free          = free;
      sender_gap();
      send_item(item);
   endtask

   // hold requests until every owed result has come back
   task automatic wait_for_results();
      idle_sender(1);
      while (upcoming_words.size() != 0) @(negedge clock);
   endtask

   // reference loads at both extremes and full-speed ticks between them
   task automatic test_set_reference();
      send_cmd(qssg_pkg::FUNC_SET_REF, 32'sh7FFF_FFFF, 4'd8);
      send_cmd(qssg_pkg::FUNC_TICK, 32'sh8000_0000, 4'd8);
      send_cmd(qssg_pkg::FUNC_SET_REF, 32'sh8000_0000, 4'd0);
      send_cmd(qssg_pkg::FUNC_TICK, 32'sh7FFF_FFFF, 4'd15);
      send_cmd(qssg_pkg::FUNC_SET_REF, 32'sh0000_0000, 4'd15);
   endtask

   // step counts from zero to the clamp, both directions, fractional parts
   task automatic test_step_rates();
      send_cmd(qssg_pkg::FUNC_TICK, ref_now, 4'd4);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now + 255, 4'd8);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now - 255, 4'd8);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now + 5 * STEP_Q8 + 128, 4'd8);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now - 7 * STEP_Q8 - 200, 4'd8);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now + 13 * STEP_Q8, 4'd8);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now + STATES * STEP_Q8, 4'd8);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now - 19 * STEP_Q8, 4'd8);
   endtask

   // full fifo drops with rollback, one slot for two words, saturated slot count
   task automatic test_fifo_slots();
      send_cmd(qssg_pkg::FUNC_TICK, ref_now + 40 * STEP_Q8, 4'd0);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now + 40 * STEP_Q8, 4'd0);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now - 12 * STEP_Q8, 4'd1);
      send_cmd(qssg_pkg::FUNC_SET_REF, ref_now + 1000, 4'd2);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now - 3 * STEP_Q8, 4'd9);
      send_cmd(qssg_pkg::FUNC_TICK, ref_now + 17 * STEP_Q8, 4'd12);
   endtask

   // mostly ticks near the reference so steps happen, some far jumps and loads
   task automatic test_random_traffic();
      int                 k;
      int                 pick;
      int                 pick_free;
      logic               func;
      logic signed [31:0] pos;
      logic [3:0]         free;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) wait_for_results();
         if (k == RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
         pick = $urandom_range(0, 99);
         func = (pick < 8) ? qssg_pkg::FUNC_SET_REF : qssg_pkg::FUNC_TICK;
         if (pick < 4 || (pick >= 8 && pick < 18))
            pos = $urandom;
         else
            pos = ref_now + $signed($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
         pick_free = $urandom_range(0, 99);
         if (pick_free < 20)
            free = 4'd0;
         else if (pick_free < 30)
            free = 4'd1;
         else if (pick_free < 40)
            free = 4'($urandom_range(9, 15));
         else
            free = 4'($urandom_range(2, 8));
         send_cmd(func, pos, free);
      end
   endtask

   initial begin
      // every input known from time zero, model in its reset state
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      phase_now      = '0;
      ref_now        = '0;
      word_acc       = '0;
      word_fill      = 0;
      phase_at_word  = '0;
      ref_at_word    = '0;
      drop_count     = '0;
      error_count    = 0;
      idling_on      = 1'b1;
      calm_items     = 0;
      stall_left     = 0;
      steady_left    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_set_reference();
      test_step_rates();
      test_fifo_slots();
      wait_for_results();
      test_random_traffic();

      // drain, then a few cycles for any stray result
      wait_for_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
